// File: hdl/htt_pkg.sv
// ----------------------------------------------------------------------------
// htt_pkg
// Shared types and constants for the heading-to-target unit: field widths,
// register indexes, the CORDIC arctangent table and the item carried from
// the classifying front end to the arctangent pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package htt_pkg;

  localparam int POS_W       = 16;
  localparam int HEADING_W   = 18;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam int ANGLE_FRAC_BITS_DEF = 8;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_X      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_Y      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ARRIVE_RADIUS = 2'd2;

  localparam logic [POS_W-1:0] TARGET_X_RST      = 16'd0;
  localparam logic [POS_W-1:0] TARGET_Y_RST      = 16'd0;
  localparam logic [POS_W-1:0] ARRIVE_RADIUS_RST = 16'd50;

  // CORDIC: 24 vectoring steps, angle in degrees with 24 fraction bits
  localparam int CORDIC_STEPS = 24;
  localparam int ACC_FRAC     = 24;
  localparam int PRESCALE     = 14;
  localparam int XY_W         = 34;
  localparam int Z_W          = 33;

  localparam logic signed [Z_W-1:0] ATAN_Q24 [CORDIC_STEPS] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367,
    234684, 117342, 58671, 29335, 14668, 7334,
    3667, 1833, 917, 458, 229, 115
  };

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic                 special;   // axis-aligned delta, heading is fixed
    logic                 negate;    // dx and dy share a sign
    logic                 add180;    // dy negative
    logic                 arrived;
    logic [HEADING_W-1:0] fixed_heading;
  } side_t;

  typedef struct packed {
    logic [POS_W-1:0] adx;
    logic [POS_W-1:0] ady;
    side_t            side;
  } item_t;

endpackage

`default_nettype wire

// File: hdl/htt_front.sv
// ----------------------------------------------------------------------------
// htt_front
// Holds the target and radius registers, takes position samples, forms the
// deltas and their magnitudes, flags arrival and classifies axis-aligned
// cases. One register stage feeds the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module htt_front #(
  parameter int ANGLE_FRAC_BITS = htt_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [htt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [htt_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic signed [htt_pkg::POS_W-1:0] pos_x,
  input  wire logic signed [htt_pkg::POS_W-1:0] pos_y,
  output logic                                item_valid,
  input  wire logic                           item_ready,
  output htt_pkg::item_t                      item
);
  import htt_pkg::*;

  localparam int HW = ANGLE_FRAC_BITS + 18;
  localparam logic signed [HW-1:0] C90  = HW'(90) << ANGLE_FRAC_BITS;
  localparam logic signed [HW-1:0] C180 = HW'(180) << ANGLE_FRAC_BITS;

  logic signed [POS_W-1:0] goal_x;
  logic signed [POS_W-1:0] goal_y;
  logic [POS_W-1:0]        arrive_radius;

  logic signed [POS_W:0] dx;
  logic signed [POS_W:0] dy;
  logic [POS_W:0]        adx_full;
  logic [POS_W:0]        ady_full;
  logic signed [HW-1:0]  fix_wide;
  item_t                 item_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      goal_x        <= TARGET_X_RST;
      goal_y        <= TARGET_Y_RST;
      arrive_radius <= ARRIVE_RADIUS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TARGET_X:      goal_x        <= cfg_data;
        REG_TARGET_Y:      goal_y        <= cfg_data;
        REG_ARRIVE_RADIUS: arrive_radius <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    dx       = {goal_x[POS_W-1], goal_x} - {pos_x[POS_W-1], pos_x};
    dy       = {goal_y[POS_W-1], goal_y} - {pos_y[POS_W-1], pos_y};
    adx_full = dx[POS_W] ? -dx : dx;
    ady_full = dy[POS_W] ? -dy : dy;

    fix_wide = '0;
    if (dy == '0) begin
      if (dx > 0)
        fix_wide = -C90;
      else if (dx < 0)
        fix_wide = C90;
    end else if (dx == '0) begin
      if (dy < 0)
        fix_wide = -C180;
    end

    item_next.adx                = adx_full[POS_W-1:0];
    item_next.ady                = ady_full[POS_W-1:0];
    item_next.side.special       = (dx == '0) || (dy == '0);
    item_next.side.negate        = (dx > 0) == (dy > 0);
    item_next.side.add180        = dy[POS_W];
    item_next.side.arrived       = (adx_full[POS_W-1:0] < arrive_radius) &&
                                   (ady_full[POS_W-1:0] < arrive_radius);
    item_next.side.fixed_heading = fix_wide[HEADING_W-1:0];
  end

  assign in_ready = !item_valid || item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= item_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/htt_queue.sv
// ----------------------------------------------------------------------------
// htt_queue
// Two-entry queue between the front end and the arctangent pipeline, so
// either side can stall without holding up the other.
// ----------------------------------------------------------------------------
`default_nettype none

module htt_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire htt_pkg::item_t push_item,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output htt_pkg::item_t      pop_item
);
  import htt_pkg::*;

  item_t       entries [QUEUE_DEPTH];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        do_push;
  logic        do_pop;

  assign push_ready = count != 2'(QUEUE_DEPTH);
  assign pop_valid  = count != 2'd0;
  assign pop_item   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push)
        wr_ptr <= !wr_ptr;
      if (do_pop)
        rd_ptr <= !rd_ptr;
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/htt_cordic.sv
// ----------------------------------------------------------------------------
// htt_cordic
// Pipelined CORDIC vectoring, one rotation per stage, followed by rounding,
// sign and quadrant correction into the output register. The whole chain
// advances whenever the output register is free or being drained.
// ----------------------------------------------------------------------------
`default_nettype none

module htt_cordic #(
  parameter int ANGLE_FRAC_BITS = htt_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                item_valid,
  output logic                                     item_ready,
  input  wire htt_pkg::item_t                      item,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [htt_pkg::HEADING_W-1:0]     heading,
  output logic                                     arrived
);
  import htt_pkg::*;

  localparam int HW = ANGLE_FRAC_BITS + 18;
  localparam int SH = ACC_FRAC - ANGLE_FRAC_BITS;
  localparam logic signed [HW-1:0]  C180 = HW'(180) << ANGLE_FRAC_BITS;
  localparam logic signed [Z_W-1:0] HALF = Z_W'(1) << (SH - 1);
  localparam int LAST = CORDIC_STEPS - 1;

  logic                    adv;
  logic signed [XY_W-1:0]  x_in;
  logic signed [XY_W-1:0]  y_in;

  logic signed [XY_W-1:0]  x_src [CORDIC_STEPS];
  logic signed [XY_W-1:0]  y_src [CORDIC_STEPS];
  logic signed [Z_W-1:0]   z_src [CORDIC_STEPS];
  side_t                   s_src [CORDIC_STEPS];
  logic                    v_src [CORDIC_STEPS];

  logic signed [XY_W-1:0]  x_q [CORDIC_STEPS];
  logic signed [XY_W-1:0]  y_q [CORDIC_STEPS];
  logic signed [Z_W-1:0]   z_q [CORDIC_STEPS];
  side_t                   s_q [CORDIC_STEPS];
  logic                    v_q [CORDIC_STEPS];

  logic signed [Z_W-1:0]   z_clamp;
  logic signed [Z_W-1:0]   z_round;
  logic signed [HW-1:0]    mag;
  logic signed [HW-1:0]    h_wide;
  logic [HEADING_W-1:0]    heading_next;

  assign adv        = !out_valid || out_ready;
  assign item_ready = adv;

  assign x_in = $signed(XY_W'(item.ady)) <<< PRESCALE;
  assign y_in = $signed(XY_W'(item.adx)) <<< PRESCALE;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;

    if (i == 0) begin : g_first
      assign x_src[i] = x_in;
      assign y_src[i] = y_in;
      assign z_src[i] = '0;
      assign s_src[i] = item.side;
      assign v_src[i] = item_valid;
    end else begin : g_next
      assign x_src[i] = x_q[i-1];
      assign y_src[i] = y_q[i-1];
      assign z_src[i] = z_q[i-1];
      assign s_src[i] = s_q[i-1];
      assign v_src[i] = v_q[i-1];
    end

    assign xs = x_src[i] >>> i;
    assign ys = y_src[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[i] <= 1'b0;
      end else if (adv) begin
        v_q[i] <= v_src[i];
      end
    end

    // rotate toward the x axis
    always_ff @(posedge clk) begin
      if (adv) begin
        s_q[i] <= s_src[i];
        if (y_src[i] > 0) begin
          x_q[i] <= x_src[i] + ys;
          y_q[i] <= y_src[i] - xs;
          z_q[i] <= z_src[i] + ATAN_Q24[i];
        end else begin
          x_q[i] <= x_src[i] - ys;
          y_q[i] <= y_src[i] + xs;
          z_q[i] <= z_src[i] - ATAN_Q24[i];
        end
      end
    end
  end

  always_comb begin
    z_clamp = z_q[LAST][Z_W-1] ? '0 : z_q[LAST];
    z_round = (z_clamp + HALF) >>> SH;
    mag     = HW'(z_round);
    h_wide  = s_q[LAST].negate ? -mag : mag;
    if (s_q[LAST].add180)
      h_wide = h_wide + C180;
    heading_next = s_q[LAST].special ? s_q[LAST].fixed_heading
                                     : h_wide[HEADING_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v_q[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      heading <= heading_next;
      arrived <= s_q[LAST].arrived;
    end
  end

endmodule

`default_nettype wire

// File: hdl/heading_to_target_unit.sv
// Throughput: one sample per cycle while the result side does not stall;
// the 24-stage CORDIC pipeline sets the latency and advances as a whole
// whenever the output register is free.
// A two-entry queue separates the classifying front end from the pipeline.
// Reset (synchronous, active high) empties all stages and sets the target
// to (0, 0) and the arrive radius to 50.
// ----------------------------------------------------------------------------
// heading_to_target_unit
// Heading in 1/2^ANGLE_FRAC_BITS degree toward a programmed target, plus an
// arrived flag, for each position sample.
// ----------------------------------------------------------------------------
`default_nettype none

module heading_to_target_unit #(
  parameter int ANGLE_FRAC_BITS = htt_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [htt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [htt_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic signed [htt_pkg::POS_W-1:0]   pos_x,
  input  wire logic signed [htt_pkg::POS_W-1:0]   pos_y,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [htt_pkg::HEADING_W-1:0]    heading,
  output logic                                    arrived
);
  import htt_pkg::*;

  logic  f_valid;
  logic  f_ready;
  item_t f_item;
  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  htt_front #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item       (f_item)
  );

  htt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  htt_cordic #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_cordic (
    .clk        (clk),
    .rst        (rst),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .heading    (heading),
    .arrived    (arrived)
  );

endmodule

`default_nettype wire

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for heading_to_target_unit. Position samples go in over
// a valid/ready channel with bursty gaps while the result side stalls on its
// own pattern. Each accepted transaction is scored against a tabled or integer CORDIC
// heading predictor and an arrived-flag check, under several target and
// radius settings, the register extremes among them.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import htt_pkg::*;

  localparam int FRAC    = ANGLE_FRAC_BITS_DEF;
  localparam int ONE     = 1 << FRAC;
  localparam int LIMIT   = 400000;
  localparam int DRAIN   = 40;
  localparam int PHASES  = 6;
  localparam int PER_PH  = 125;
  localparam int DIR_N   = 25;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam logic [HEADING_W-1:0] HD_ZERO   = '0;
  localparam logic [HEADING_W-1:0] HD_NEG90  = HEADING_W'(-90 * ONE);
  localparam logic [HEADING_W-1:0] HD_POS90  = HEADING_W'(90 * ONE);
  localparam logic [HEADING_W-1:0] HD_NEG180 = HEADING_W'(-180 * ONE);

  typedef struct packed {
    logic [POS_W-1:0]     px;
    logic [POS_W-1:0]     py;
    logic                 known;
    logic [HEADING_W-1:0] hd;
    logic                 arr;
  } sample_row_t;

  typedef struct packed {
    logic [HEADING_W-1:0] hd;
    logic                 arr;
  } heading_item_t;

  // Target and radius at reset: dx = -pos_x, dy = -pos_y, radius 50
  localparam sample_row_t SAMPLES [DIR_N] = '{
    '{16'sd0,      16'sd0,      1'b1, HD_ZERO,   1'b1},
    '{-16'sd100,   16'sd0,      1'b1, HD_NEG90,  1'b0},
    '{16'sd100,    16'sd0,      1'b1, HD_POS90,  1'b0},
    '{16'sd0,      16'sd100,    1'b1, HD_NEG180, 1'b0},
    '{16'sd0,      -16'sd100,   1'b1, HD_ZERO,   1'b0},
    '{-16'sd32768, 16'sd0,      1'b1, HD_NEG90,  1'b0},
    '{16'sd32767,  16'sd0,      1'b1, HD_POS90,  1'b0},
    '{16'sd0,      -16'sd32768, 1'b1, HD_ZERO,   1'b0},
    '{16'sd0,      16'sd32767,  1'b1, HD_NEG180, 1'b0},
    '{16'sd49,     16'sd0,      1'b1, HD_POS90,  1'b1},
    '{16'sd50,     16'sd0,      1'b1, HD_POS90,  1'b0},
    '{16'sd0,      -16'sd49,    1'b1, HD_ZERO,   1'b1},
    '{16'sd0,      -16'sd50,    1'b1, HD_ZERO,   1'b0},
    '{-16'sd49,    -16'sd49,    1'b0, HD_ZERO,   1'b0},
    '{-16'sd100,   -16'sd100,   1'b0, HD_ZERO,   1'b0},
    '{16'sd100,    -16'sd100,   1'b0, HD_ZERO,   1'b0},
    '{-16'sd100,   16'sd100,    1'b0, HD_ZERO,   1'b0},
    '{16'sd100,    16'sd100,    1'b0, HD_ZERO,   1'b0},
    '{-16'sd32768, -16'sd32768, 1'b0, HD_ZERO,   1'b0},
    '{16'sd32767,  16'sd32767,  1'b0, HD_ZERO,   1'b0},
    '{-16'sd32768, 16'sd32767,  1'b0, HD_ZERO,   1'b0},
    '{16'sd32767,  -16'sd32768, 1'b0, HD_ZERO,   1'b0},
    '{-16'sd32768, 16'sd1,      1'b0, HD_ZERO,   1'b0},
    '{16'sd32767,  -16'sd1,     1'b0, HD_ZERO,   1'b0},
    '{-16'sd1,     -16'sd32768, 1'b0, HD_ZERO,   1'b0}
  };

  logic                        clk;
  logic                        rst;
  logic                        cfg_we;
  logic [CFG_IDX_W-1:0]        cfg_index;
  logic [CFG_DATA_W-1:0]       cfg_data;
  logic                        in_valid;
  logic                        in_ready;
  logic signed [POS_W-1:0]     pos_x;
  logic signed [POS_W-1:0]     pos_y;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic signed [HEADING_W-1:0] heading;
  logic                        arrived;

  logic signed [POS_W-1:0] tgt_x;
  logic signed [POS_W-1:0] tgt_y;
  logic [POS_W-1:0]        arrive_r;

  heading_item_t headings_due[$];
  int            errors = 0;
  int            cycles = 0;
  int            burst_left = 0;

  heading_to_target_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .heading   (heading),
    .arrived   (arrived)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Arctangent magnitude of ay/ax in degrees, rounded to FRAC fraction bits
  function automatic longint cordic_degrees(longint ax, longint ay);
    longint x;
    longint y;
    longint z;
    longint xs;
    longint ys;
    int     sh;
    x  = ax <<< PRESCALE;
    y  = ay <<< PRESCALE;
    z  = 0;
    sh = ACC_FRAC - FRAC;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(ATAN_Q24[i]);
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(ATAN_Q24[i]);
      end
    end
    if (z < 0) z = 0;
    return (z + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic heading_item_t predict_heading(logic signed [POS_W-1:0] px,
                                                    logic signed [POS_W-1:0] py);
    heading_item_t r;
    longint dx;
    longint dy;
    longint adx;
    longint ady;
    longint h;
    longint a;
    dx  = longint'(tgt_x) - longint'(px);
    dy  = longint'(tgt_y) - longint'(py);
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    h   = 0;
    if (dy == 0) begin
      if (dx > 0) h = -90 * ONE;
      else if (dx < 0) h = 90 * ONE;
    end else if (dx == 0) begin
      if (dy < 0) h = -180 * ONE;
    end else begin
      a = cordic_degrees(ady, adx);
      h = ((dx > 0) == (dy > 0)) ? -a : a;
      if (dy < 0) h = h + 180 * ONE;
    end
    r.hd  = h[HEADING_W-1:0];
    r.arr = (adx < longint'(arrive_r)) && (ady < longint'(arrive_r));
    return r;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_TARGET_X:      tgt_x = data;
      REG_TARGET_Y:      tgt_y = data;
      REG_ARRIVE_RADIUS: arrive_r = data;
      default: ;
    endcase
  endtask

  // Send one sample after an optional burst gap, then queue its expected result
  task automatic send_sample(logic signed [POS_W-1:0] px, logic signed [POS_W-1:0] py,
                             logic known, heading_item_t typed);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 32);
    end
    burst_left--;
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    pos_x    = px;
    pos_y    = py;
    do @(posedge clk); while (!in_ready);
    headings_due.push_back(known ? typed : predict_heading(px, py));
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (headings_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // Receiver stall pattern: switch the stall rate at random intervals
  initial begin
    int stall_pct;
    int hold;
    stall_pct = 0;
    hold      = 0;
    forever begin
      @(negedge clk);
      if (hold == 0) begin
        case ($urandom_range(0, 4))
          0, 1:    stall_pct = 0;
          2:       stall_pct = 25;
          3:       stall_pct = 50;
          default: stall_pct = 85;
        endcase
        hold = $urandom_range(64, 256);
      end
      hold--;
      out_ready = ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    heading_item_t due;
    if (!rst && out_valid && out_ready) begin
      if (headings_due.size() == 0) begin
        $display("%0t: result with nothing expected: heading %0d arrived %0b",
                 $realtime, heading, arrived);
        errors++;
      end else begin
        due = headings_due.pop_front();
        if (heading !== due.hd) begin
          $display("%0t: heading expected %0d actual %0d",
                   $realtime, $signed(due.hd), heading);
          errors++;
        end
        if (arrived !== due.arr) begin
          $display("%0t: arrived expected %0b actual %0b", $realtime, due.arr, arrived);
          errors++;
        end
      end
    end
  end

  initial begin
    heading_item_t           typed;
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    int                      lim;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    pos_x     = '0;
    pos_y     = '0;
    tgt_x     = TARGET_X_RST;
    tgt_y     = TARGET_Y_RST;
    arrive_r  = ARRIVE_RADIUS_RST;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (SAMPLES[i]) begin
      typed.hd  = SAMPLES[i].hd;
      typed.arr = SAMPLES[i].arr;
      send_sample(SAMPLES[i].px, SAMPLES[i].py, SAMPLES[i].known, typed);
    end
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          write_reg(REG_TARGET_X, 16'h7fff);
          write_reg(REG_TARGET_Y, 16'h8000);
          write_reg(REG_ARRIVE_RADIUS, 16'd0);
        end
        1: begin
          write_reg(REG_TARGET_X, 16'h8000);
          write_reg(REG_TARGET_Y, 16'h7fff);
          write_reg(REG_ARRIVE_RADIUS, 16'hffff);
        end
        2: begin
          write_reg(REG_TARGET_X, 16'h0000);
          write_reg(REG_TARGET_Y, 16'h0000);
          write_reg(REG_ARRIVE_RADIUS, 16'd1);
        end
        3: begin
          write_reg(REG_TARGET_X, 16'($urandom));
          write_reg(REG_TARGET_Y, 16'($urandom));
          write_reg(REG_ARRIVE_RADIUS, 16'($urandom_range(0, 300)));
        end
        4: begin
          write_reg(REG_TARGET_X, 16'($urandom));
          write_reg(REG_TARGET_Y, 16'($urandom));
          write_reg(REG_ARRIVE_RADIUS, 16'($urandom));
        end
        default: begin
          write_reg(REG_TARGET_X, 16'($urandom));
          write_reg(REG_TARGET_Y, 16'($urandom));
          write_reg(REG_ARRIVE_RADIUS, ARRIVE_RADIUS_RST);
        end
      endcase
      // Unmapped index must leave all registers alone
      write_reg(REG_UNUSED, 16'($urandom));

      lim = (int'(arrive_r) > 300) ? 300 : int'(arrive_r) + 1;
      for (int n = 0; n < PER_PH; n++) begin
        px = 16'($urandom);
        py = 16'($urandom);
        case ($urandom_range(0, 9))
          0, 1: px = tgt_x;
          2, 3: py = tgt_y;
          4: begin
            px = tgt_x;
            py = tgt_y;
          end
          5, 6: begin
            px = tgt_x + 16'($urandom_range(0, 2 * lim) - lim);
            py = tgt_y + 16'($urandom_range(0, 2 * lim) - lim);
          end
          default: ;
        endcase
        send_sample(px, py, 1'b0, typed);
      end
      drain();
    end

    if (headings_due.size() != 0) begin
      $display("%0t: %0d results never arrived", $realtime, headings_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
